[design/ihex_pkg.sv]
// Shared constants, types and the hex digit function of the Intel HEX record encoder.
package ihex_pkg;

    localparam int RECORD_BYTES = 16;

    localparam logic       MODE_DATA = 1'b0;
    localparam logic       MODE_END  = 1'b1;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [7:0] REC_DATA  = 8'h00;
    localparam logic [7:0] REC_EOF   = 8'h01;
    localparam logic [7:0] REC_ELA   = 8'h04;

    localparam logic [4:0] ELA_COUNT = 5'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    // Upper case ASCII hex digit of one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10) begin
            hex_char = 8'h30 + wide;
        end else begin
            hex_char = 8'h37 + wide;
        end
    endfunction

endpackage

[design/intel_hex_record_encoder_top.sv]
// Intel HEX record encoder: byte stream in, one ASCII character of record text per transaction out.
// An input transaction that starts a record moves the sequencer to its emit state, and the record then
// moves one character per cycle while the output side takes it.
// The single record sequencer prints every record; input waits while it is busy.
// Reset (i_rst_n, synchronous, active low) clears the sequencer, fill count, flags and start address.
module intel_hex_record_encoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input item channel.
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_mode,
    input  logic [7:0] i_data_byte,
    // Text character channel.
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_text_char,
    output logic       o_last_char,
    // Start address write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_start_address
);
    import ihex_pkg::*;

    // Every record is printed by the same sequencer as a list of bytes:
    // count, address high, address low, type, payload, checksum. The end
    // of file record is simply a record with count 0 and type 01, and the
    // extended linear address record has count 2 with the upper address
    // half as payload. A single 8-bit adder accumulates the checksum as
    // each byte goes out, so no separate sum is kept for the line.

    t_state      r_state, n_state;
    logic [5:0]  r_pos, n_pos;
    logic [7:0]  r_acc, n_acc;
    logic        r_do_ela, n_do_ela;
    logic        r_do_data, n_do_data;
    logic        r_do_eof, n_do_eof;
    logic [4:0]  r_fill, n_fill;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_start, n_start;
    logic        r_started, n_started;
    logic        r_fin, n_fin;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_char, n_out_char;
    logic        r_out_last, n_out_last;
    logic [7:0]  r_line_buf [RECORD_BYTES];

    logic        in_accept;
    logic        emit_go;
    logic        kind_ela, kind_data;
    logic [4:0]  rec_cnt;
    logic [7:0]  rec_type;
    logic [5:0]  last_pos;
    logic [5:0]  hex_pos;
    logic [4:0]  byte_idx;
    logic [4:0]  cks_idx;
    logic [3:0]  buf_idx;
    logic [7:0]  cur_byte;
    logic [7:0]  cur_char;
    logic        last_rec;
    logic        open_ela;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_text_char = r_out_char;
    assign o_last_char = r_out_last;

    assign in_accept = i_in_valid && o_in_ready;
    assign emit_go   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign open_ela  = !r_started && (r_addr[15:0] == 16'h0000);

    // Which record is being printed: address record first, then data, then end of file.
    assign kind_ela  = r_do_ela;
    assign kind_data = !r_do_ela && r_do_data;

    always_comb begin
        if (kind_ela) begin
            rec_cnt  = ELA_COUNT;
            rec_type = REC_ELA;
            last_rec = !r_do_data && !r_do_eof;
        end else if (kind_data) begin
            rec_cnt  = r_fill;
            rec_type = REC_DATA;
            last_rec = !r_do_eof;
        end else begin
            rec_cnt  = 5'd0;
            rec_type = REC_EOF;
            last_rec = 1'b1;
        end
    end

    // Position 0 is the colon, then two hex digits per byte, then the line feed.
    assign last_pos = {rec_cnt, 1'b0} + 6'd11;
    assign hex_pos  = r_pos - 6'd1;
    assign byte_idx = hex_pos[5:1];
    assign cks_idx  = rec_cnt + 5'd4;
    assign buf_idx  = 4'(byte_idx - 5'd4);

    always_comb begin
        if (byte_idx == 5'd0) begin
            cur_byte = {3'b000, rec_cnt};
        end else if (byte_idx == 5'd1) begin
            cur_byte = kind_data ? r_addr[15:8] : 8'h00;
        end else if (byte_idx == 5'd2) begin
            cur_byte = kind_data ? r_addr[7:0] : 8'h00;
        end else if (byte_idx == 5'd3) begin
            cur_byte = rec_type;
        end else if (byte_idx == cks_idx) begin
            cur_byte = 8'h00 - r_acc;
        end else if (kind_ela) begin
            cur_byte = (byte_idx == 5'd4) ? r_addr[31:24] : r_addr[23:16];
        end else begin
            cur_byte = r_line_buf[buf_idx];
        end
    end

    always_comb begin
        if (r_pos == 6'd0) begin
            cur_char = CH_COLON;
        end else if (r_pos == last_pos) begin
            cur_char = CH_LF;
        end else if (hex_pos[0]) begin
            cur_char = hex_char(cur_byte[3:0]);
        end else begin
            cur_char = hex_char(cur_byte[7:4]);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_do_ela    = r_do_ela;
        n_do_data   = r_do_data;
        n_do_eof    = r_do_eof;
        n_fill      = r_fill;
        n_addr      = r_addr;
        n_start     = r_start;
        n_started   = r_started;
        n_fin       = r_fin;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // The start address also moves the current address while no line is open and no end marker was taken.
        if (i_cfg_valid) begin
            n_start = i_start_address;
            if (!r_started && !r_fin) begin
                n_addr = i_start_address;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                // Items after the end marker are taken and dropped.
                if (in_accept && !r_fin) begin
                    n_started = 1'b1;
                    n_do_ela  = open_ela;
                    n_pos     = 6'd0;
                    if (i_mode == MODE_DATA) begin
                        n_fill    = r_fill + 5'd1;
                        n_do_data = (r_fill == 5'(RECORD_BYTES - 1));
                        n_do_eof  = 1'b0;
                        if (open_ela || (r_fill == 5'(RECORD_BYTES - 1))) begin
                            n_state = S_EMIT;
                        end
                    end else begin
                        n_fin     = 1'b1;
                        n_do_data = (r_fill != 5'd0);
                        n_do_eof  = 1'b1;
                        n_state   = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_out_valid = 1'b1;
                    n_out_char  = cur_char;
                    n_out_last  = 1'b0;
                    n_pos       = r_pos + 6'd1;
                    if (r_pos == 6'd0) begin
                        n_acc = 8'h00;
                    end else if (r_pos != last_pos && !hex_pos[0] && byte_idx != cks_idx) begin
                        n_acc = r_acc + cur_byte;
                    end
                    if (r_pos == last_pos) begin
                        n_pos      = 6'd0;
                        n_out_last = last_rec;
                        if (kind_ela) begin
                            n_do_ela = 1'b0;
                        end else if (kind_data) begin
                            n_do_data = 1'b0;
                            n_addr    = r_addr + {27'd0, r_fill};
                            n_fill    = 5'd0;
                            n_started = 1'b0;
                        end else begin
                            n_do_eof = 1'b0;
                        end
                        if (last_rec) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= 6'd0;
            r_acc       <= 8'h00;
            r_do_ela    <= 1'b0;
            r_do_data   <= 1'b0;
            r_do_eof    <= 1'b0;
            r_fill      <= 5'd0;
            r_addr      <= 32'd0;
            r_start     <= 32'd0;
            r_started   <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_acc       <= n_acc;
            r_do_ela    <= n_do_ela;
            r_do_data   <= n_do_data;
            r_do_eof    <= n_do_eof;
            r_fill      <= n_fill;
            r_addr      <= n_addr;
            r_start     <= n_start;
            r_started   <= n_started;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
        end
    end

    // Payload registers: the output character and the line bytes.
    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        if (in_accept && !r_fin && i_mode == MODE_DATA) begin
            r_line_buf[r_fill[3:0]] <= i_data_byte;
        end
    end

    // A full line is always flushed before the next byte can be taken.
    a_fill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_fill < 5'(RECORD_BYTES)))
        else $error("line left full while idle");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_pos <= last_pos))
        else $error("character position ran past the line feed");

    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_char == CH_LF))
        else $error("final character of a run is not a line feed");

    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin && r_state == S_IDLE) |=> (r_state == S_IDLE))
        else $error("records emitted after the end marker");

    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_do_ela || r_do_data || r_do_eof))
        else $error("sequencer busy with no record pending");

endmodule

[verif/intel_hex_record_encoder_top_tb.sv]
// Self-checking testbench of the Intel HEX record encoder: directed corners, random traffic, end of input.
`timescale 1ns / 100ps

module intel_hex_record_encoder_top_tb;
    import ihex_pkg::*;

    // The watchdog gives up after this many cycles with no transaction on any channel.
    localparam int STALL_LIMIT = 2000;
    // Idle cycles allowed before a register write, and after the last character.
    localparam int PAUSE_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_PRINTED = 50;

    // One character of record text as it should leave the block.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_mode;
    logic [7:0]  in_data;
    logic        out_ready;
    logic        cfg_valid;
    logic [31:0] cfg_addr;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_text_char;
    logic        o_last_char;
    logic        o_cfg_ready;

    // Percent chances of the sender idling and of the receiver stalling in a cycle.
    int          src_idle_pct;
    int          snk_stall_pct;
    int          mismatch_cnt;
    int          quiet_cycles;

    // Characters still owed by the block, oldest first.
    t_text_beat  text_q[$];
    t_text_beat  text_head;
    // Characters of the transaction being encoded by the predictor.
    logic [7:0]  record_chars[$];

    // Predictor state: a shadow of the encoder's line, address and flags.
    logic [31:0] hex_line_addr;
    logic [7:0]  hex_line[16];
    int unsigned hex_fill;
    logic [7:0]  hex_sum;
    bit          hex_line_open;
    bit          hex_done;

    intel_hex_record_encoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (in_mode),
        .i_data_byte     (in_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_text_char     (o_text_char),
        .o_last_char     (o_last_char),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_start_address (cfg_addr)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor. Every character an input transaction causes is gathered in
    // record_chars, then moved to text_q with the last one flagged.
    // ------------------------------------------------------------------

    function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'h0, nib};
        end
        return 8'h41 + {4'h0, nib} - 8'd10;
    endfunction

    function automatic void put_hex(input logic [7:0] value);
        record_chars.push_back(nibble_ascii(value[7:4]));
        record_chars.push_back(nibble_ascii(value[3:0]));
    endfunction

    // Opening a line emits an extended linear address record only when the
    // line begins on a 64K boundary; otherwise it just marks the line open.
    function automatic void open_line();
        logic [7:0] hi;
        logic [7:0] lo;
        hi = hex_line_addr[31:24];
        lo = hex_line_addr[23:16];
        hex_line_open = 1'b1;
        if (hex_line_addr[15:0] == 16'h0000) begin
            record_chars.push_back(CH_COLON);
            put_hex({3'b000, ELA_COUNT});
            put_hex(8'h00);
            put_hex(8'h00);
            put_hex(REC_ELA);
            put_hex(hi);
            put_hex(lo);
            put_hex(8'h00 - ({3'b000, ELA_COUNT} + REC_ELA + hi + lo));
            record_chars.push_back(CH_LF);
        end
    endfunction

    // A data record covers the bytes held so far; only the low 16 address bits
    // appear, so a line that runs over a 64K boundary stays in one record.
    function automatic void flush_line();
        logic [7:0] count;
        count = 8'(hex_fill);
        record_chars.push_back(CH_COLON);
        put_hex(count);
        put_hex(hex_line_addr[15:8]);
        put_hex(hex_line_addr[7:0]);
        put_hex(REC_DATA);
        for (int i = 0; i < hex_fill; i++) begin
            put_hex(hex_line[i]);
        end
        put_hex(8'h00 - (hex_sum + count + hex_line_addr[15:8] + hex_line_addr[7:0]));
        record_chars.push_back(CH_LF);
        hex_line_addr = hex_line_addr + hex_fill;
        hex_fill = 0;
        hex_sum = 8'h00;
        hex_line_open = 1'b0;
    endfunction

    function automatic void encode_item(input logic mode, input logic [7:0] data);
        record_chars.delete();
        // Once the end marker has gone through, the block drops everything.
        if (!hex_done) begin
            if (!hex_line_open) begin
                open_line();
            end
            if (mode == MODE_DATA) begin
                hex_line[hex_fill] = data;
                hex_sum = hex_sum + data;
                hex_fill++;
                if (hex_fill >= RECORD_BYTES) begin
                    flush_line();
                end
            end else begin
                if (hex_fill > 0) begin
                    flush_line();
                end
                // End of file record, checksum included.
                record_chars.push_back(CH_COLON);
                put_hex(8'h00);
                put_hex(8'h00);
                put_hex(8'h00);
                put_hex(REC_EOF);
                put_hex(8'h00 - REC_EOF);
                record_chars.push_back(CH_LF);
                hex_done = 1'b1;
            end
        end
        foreach (record_chars[i]) begin
            text_q.push_back('{ch: record_chars[i], last: (i == record_chars.size() - 1)});
        end
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers. Inputs change at the falling edge; transactions are
    // recognized at the rising edge.
    // ------------------------------------------------------------------

    task automatic log_mismatch(input string what);
        if (mismatch_cnt < MAX_PRINTED) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        mismatch_cnt++;
    endtask

    // Valid is left high after a transaction until the next falling edge, where
    // it is either lowered for an idle cycle or carries the next item. That way
    // valid gets a single assignment per time step.
    task automatic send_item(input logic mode, input logic [7:0] data);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_data  <= data;
        do @(posedge i_clk); while (!o_in_ready);
        encode_item(mode, data);
    endtask

    task automatic write_start_address(input logic [31:0] addr);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        // The new start address only moves the line address when no line is
        // open and the end marker has not been seen.
        if (!hex_line_open && !hex_done) begin
            hex_line_addr = addr;
        end
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending, let every owed character come out, then pause, since a byte
    // that opens or closes no record yields no character to wait for.
    task automatic drain_and_pause();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (text_q.size() != 0) @(posedge i_clk);
        repeat (PAUSE_CYCLES) @(posedge i_clk);
    endtask

    // Start addresses weighted toward the cases that matter: 64K boundaries,
    // lines that end right at or across one, and the two extremes.
    function automatic logic [31:0] pick_start_address();
        logic [15:0] upper;
        upper = 16'($urandom);
        case ($urandom_range(5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return {upper, 16'h0000};
            3: return {upper, 16'hFFF0};
            4: return {upper, 16'hFFF0 | 16'($urandom_range(15))};
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // A full line that starts 8 bytes below the top of the address space: the
    // record shows address FFF8, carries the byte extremes, and the line
    // address wraps to 8 afterwards.
    task automatic test_wrap_line();
        logic [7:0] corner_bytes[16];
        corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA,
                         8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'h10, 8'hEF, 8'h99, 8'h66};
        write_start_address(32'hFFFF_FFF8);
        foreach (corner_bytes[i]) begin
            send_item(MODE_DATA, corner_bytes[i]);
        end
    endtask

    // Address zero opens with an extended linear address record. A write
    // that lands while the line is open changes the register but not the
    // address of the line in progress.
    task automatic test_write_mid_line();
        drain_and_pause();
        write_start_address(32'h0000_0000);
        send_item(MODE_DATA, 8'h01);
        send_item(MODE_DATA, 8'h02);
        send_item(MODE_DATA, 8'h03);
        drain_and_pause();
        write_start_address(32'hFFFF_0000);
        send_item(MODE_DATA, 8'hA5);
        send_item(MODE_DATA, 8'h5A);
    endtask

    // Bursts of random bytes, each after a fresh start address. Most bursts are
    // whole lines so that the new address usually takes effect.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        int sent;
        int burst;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            drain_and_pause();
            write_start_address(pick_start_address());
            if ($urandom_range(3) != 0) begin
                burst = 16 * $urandom_range(1, 3);
            end else begin
                burst = $urandom_range(1, 20);
            end
            repeat (burst) send_item(MODE_DATA, 8'($urandom_range(255)));
            sent += burst;
        end
    endtask

    // The end marker flushes whatever is pending (or, with nothing pending on a
    // 64K boundary, opens with an address record) and then closes the file.
    // Everything after it, register writes included, has no visible effect.
    task automatic test_end_of_input();
        src_idle_pct  = 30;
        snk_stall_pct = 30;
        drain_and_pause();
        if ($urandom_range(1) != 0) begin
            write_start_address({16'($urandom), 16'h0000});
        end
        repeat ($urandom_range(15)) send_item(MODE_DATA, 8'($urandom_range(255)));
        send_item(MODE_END, 8'($urandom_range(255)));
        repeat (4) send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
        drain_and_pause();
        write_start_address($urandom);
        send_item(MODE_DATA, 8'($urandom_range(255)));
        send_item(MODE_END, 8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog.
    // ------------------------------------------------------------------

    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Each character taken from the block is held against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (text_q.size() == 0) begin
                log_mismatch($sformatf("unexpected character 0x%02h", o_text_char));
            end else begin
                text_head = text_q.pop_front();
                if (o_text_char !== text_head.ch) begin
                    log_mismatch($sformatf("text_char 0x%02h, expected 0x%02h",
                                           o_text_char, text_head.ch));
                end
                if (o_last_char !== text_head.last) begin
                    log_mismatch($sformatf("last_char %0b, expected %0b on 0x%02h",
                                           o_last_char, text_head.last, text_head.ch));
                end
            end
        end
    end

    // Any transaction on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------

    initial begin
        i_rst_n       = 1'b0;
        in_valid      = 1'b0;
        in_mode       = MODE_DATA;
        in_data       = 8'h00;
        cfg_valid     = 1'b0;
        cfg_addr      = 32'h0000_0000;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        mismatch_cnt  = 0;

        // Shadow state matches the block after reset.
        hex_line_addr  = 32'h0000_0000;
        hex_fill       = 0;
        hex_sum        = 8'h00;
        hex_line_open  = 1'b0;
        hex_done       = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_wrap_line();
        test_write_mid_line();
        test_random_traffic(0, 0, 40);
        test_random_traffic(47, 0, 40);
        test_random_traffic(0, 47, 40);
        test_random_traffic(30, 30, 40);
        test_end_of_input();

        drain_and_pause();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
design/ihex_pkg.sv
design/intel_hex_record_encoder_top.sv
verif/intel_hex_record_encoder_top_tb.sv
